// ===== rtl/trd_pkg.sv =====
// Shared types and constants for the record deframer.
package trd_pkg;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_BADHDR   = 2'd2,
        KIND_OVERSIZE = 2'd3
    } kind_t;

    localparam logic [7:0] HDR_B0 = 8'h17;
    localparam logic [7:0] HDR_B1 = 8'h03;
    localparam logic [7:0] HDR_B2 = 8'h03;

    localparam logic [2:0] HDR_POS_B0     = 3'd0;
    localparam logic [2:0] HDR_POS_B1     = 3'd1;
    localparam logic [2:0] HDR_POS_B2     = 3'd2;
    localparam logic [2:0] HDR_POS_LEN_HI = 3'd3;
    localparam logic [2:0] HDR_POS_LEN_LO = 3'd4;

    localparam logic [16:0] LIMIT_RESET = 17'd1995;

    typedef struct packed {
        logic       hit;
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       record_end;
    } result_t;

endpackage

// ===== rtl/trd_rx_if.sv =====
// Received byte stream channel.
interface trd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/trd_tx_if.sv =====
// Deframed result channel.
interface trd_tx_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       record_end;

    modport source (output valid, output kind, output payload_byte, output record_end,
                    input ready);
    modport sink (input valid, input kind, input payload_byte, input record_end,
                  output ready);
endinterface

// ===== rtl/trd_cfg_if.sv =====
// Configuration write channel for the length limit.
interface trd_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] length_limit;

    modport source (output valid, output length_limit, input ready);
    modport sink (input valid, input length_limit, output ready);
endinterface

// ===== rtl/trd_parser.sv =====
// Header/payload parser: framing state and per-byte result logic.
module trd_parser
    import trd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  rx_byte,
    input  logic [16:0] length_limit,
    output result_t     result
);

    logic [2:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        in_payload_reg, in_payload_next;
    logic        halted_reg, halted_next;
    logic [15:0] len;
    logic        last;

    assign pos_eff = (pos_reg > HDR_POS_LEN_LO) ? HDR_POS_B0 : pos_reg;
    assign len     = {len_hi_reg, rx_byte};
    assign last    = (remaining_reg <= 16'd1);

    always_comb
    begin
        pos_next            = pos_reg;
        len_hi_next         = len_hi_reg;
        remaining_next      = remaining_reg;
        in_payload_next     = in_payload_reg;
        halted_next         = halted_reg;
        result.hit          = 1'b0;
        result.kind         = KIND_DATA;
        result.payload_byte = 8'd0;
        result.record_end   = 1'b0;

        if (halted_reg)
        begin
            // stream closed: drop everything
        end
        else if (in_payload_reg)
        begin
            result.hit          = 1'b1;
            result.payload_byte = rx_byte;
            result.record_end   = last;
            if (last)
            begin
                remaining_next  = 16'd0;
                in_payload_next = 1'b0;
            end
            else
            begin
                remaining_next = remaining_reg - 16'd1;
            end
        end
        else
        begin
            case (pos_eff)
                HDR_POS_B0, HDR_POS_B1, HDR_POS_B2:
                begin
                    if (rx_byte != ((pos_eff == HDR_POS_B0) ? HDR_B0 :
                                    (pos_eff == HDR_POS_B1) ? HDR_B1 : HDR_B2))
                    begin
                        halted_next = 1'b1;
                        result.hit  = 1'b1;
                        result.kind = KIND_BADHDR;
                    end
                    else
                    begin
                        pos_next = pos_eff + 3'd1;
                    end
                end
                HDR_POS_LEN_HI:
                begin
                    len_hi_next = rx_byte;
                    pos_next    = HDR_POS_LEN_LO;
                end
                default:
                begin
                    pos_next = HDR_POS_B0;
                    if ({1'b0, len} >= length_limit)
                    begin
                        halted_next = 1'b1;
                        result.hit  = 1'b1;
                        result.kind = KIND_OVERSIZE;
                    end
                    else if (len == 16'd0)
                    begin
                        result.hit        = 1'b1;
                        result.kind       = KIND_EMPTY;
                        result.record_end = 1'b1;
                    end
                    else
                    begin
                        remaining_next  = len;
                        in_payload_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= HDR_POS_B0;
            len_hi_reg     <= 8'd0;
            remaining_reg  <= 16'd0;
            in_payload_reg <= 1'b0;
            halted_reg     <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg        <= pos_next;
            len_hi_reg     <= len_hi_next;
            remaining_reg  <= remaining_next;
            in_payload_reg <= in_payload_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

// ===== rtl/trd_out_stage.sv =====
// Result register driving the output channel.
module trd_out_stage
    import trd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    result,
    output logic       can_take,
    trd_tx_if.source   tx
);

    logic       valid_reg, valid_next;
    kind_t      kind_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign can_take   = !valid_reg || tx.ready;
    assign valid_next = load ? 1'b1 : (tx.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= result.kind;
            byte_reg <= result.payload_byte;
            end_reg  <= result.record_end;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.kind         = kind_reg;
    assign tx.payload_byte = byte_reg;
    assign tx.record_end   = end_reg;

endmodule

// ===== rtl/tls_style_record_deframer.sv =====
// Top level of the record deframer.
// Takes one stream byte per beat and sustains one byte per clock. A byte is
// held in an input register and parsed against the header/payload state. Its
// result, if it has one, is loaded into the result register when the byte
// moves on from the input register, and that register drives tx. rx stalls
// only while a result is waiting on tx with tx.ready low.
// Correct header bytes give no result. After a bad header or an oversize
// length every byte is dropped until reset. The user must write the length limit
// on cfg only while the block is idle; the block itself does not enforce this.
module tls_style_record_deframer
    import trd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    trd_rx_if.sink   rx,
    trd_tx_if.source tx,
    trd_cfg_if.sink  cfg
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [16:0] limit_reg;
    logic        can_take;
    logic        advance;
    logic        rx_fire;
    result_t     result;

    assign advance       = in_valid_reg && can_take;
    assign rx.ready      = !in_valid_reg || advance;
    assign rx_fire       = rx.valid && rx.ready;
    assign in_valid_next = rx_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.length_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    trd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .rx_byte      (in_byte_reg),
        .length_limit (limit_reg),
        .result       (result)
    );

    trd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && result.hit),
        .result   (result),
        .can_take (can_take),
        .tx       (tx)
    );

endmodule
